FILE: rtl/sfr_pkg.sv
// Package for the sensor frame receiver: shared constants and the sequencer state type.
// No dependencies.
package sfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 32;
    localparam int CNT_W               = 6;   // body byte counter width

    localparam logic [7:0] START_FIRST  = 8'h42;
    localparam logic [7:0] START_SECOND = 8'h4D;

    typedef enum logic [7:0] {
        ST_HUNT1  = 8'b0000_0001,
        ST_HUNT2  = 8'b0000_0010,
        ST_LEN_HI = 8'b0000_0100,
        ST_LEN_LO = 8'b0000_1000,
        ST_BODY   = 8'b0001_0000,
        ST_RDHI   = 8'b0010_0000,
        ST_RDLO   = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } t_state;

endpackage

FILE: rtl/sfr_if.sv
// Handshake interfaces for the sensor frame receiver: received-byte channel and result channel.
// No dependencies.
interface sfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_word_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic [15:0] frame_length;
    logic        frame_ok;
    logic        last;

    modport source (output valid, output word_index, output word_value, output frame_length,
                    output frame_ok, output last, input ready);
    modport sink   (input valid, input word_index, input word_value, input frame_length,
                    input frame_ok, input last, output ready);
endinterface

FILE: rtl/sensor_frame_receiver.sv
// Top level of the sensor frame receiver: frame parser, checksum accumulator and word emitter.
// Depends on sfr_pkg, sfr_if and sfr_store.
//
//   channel   dir  payload                                               transaction when
//   i_rx      in   rx_byte[7:0]                                          valid && ready
//   o_res     out  word_index[3:0] word_value[15:0] frame_length[15:0]   valid && ready
//                  frame_ok last
//
// Bytes are taken while i_rx.ready is high. After the last byte of a good frame the sequencer
// reads the buffer port twice per payload word (ST_RDHI, ST_RDLO, ST_EMIT; up to 13 words)
// while i_rx.ready is low. The single output register is the only result buffer; a
// stalled o_res holds the burst. Synchronous active-low reset returns to hunting.
module sensor_frame_receiver #(
    parameter int MAX_FRAME_BYTES = sfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfr_byte_if.sink    i_rx,
    sfr_word_if.source  o_res
);
    import sfr_pkg::*;

    localparam int DEPTH = MAX_FRAME_BYTES - 4;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [15:0] DEPTH16 = 16'(DEPTH);

    t_state           r_state, n_state;
    logic [15:0]      r_len, n_len;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]      r_sum, n_sum;
    logic [7:0]       r_chk_hi, n_chk_hi;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [7:0]       r_hi, n_hi;

    logic        r_ov, n_ov;
    logic [3:0]  r_o_idx, n_o_idx;
    logic [15:0] r_o_val, n_o_val;
    logic [15:0] r_o_len, n_o_len;
    logic        r_o_ok, n_o_ok;
    logic        r_o_last, n_o_last;

    logic           w_out_free, w_rdy, w_acc;
    logic [7:0]     w_b;
    logic [15:0]    w_len_lo, w_data_bytes, w_cnt16, w_cnt_inc16, w_pos16;
    logic [CNT_W-1:0] w_cnt_inc, w_pos_inc;
    logic           w_mem_we, w_mem_re;
    logic [AW-1:0]  w_raddr;
    logic [7:0]     w_rdata;

    sfr_store #(.DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (w_b),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_b          = i_rx.rx_byte;
    assign w_out_free   = !r_ov || o_res.ready;
    assign w_rdy        = (r_state == ST_HUNT1 || r_state == ST_HUNT2 || r_state == ST_LEN_HI
                           || r_state == ST_LEN_LO || r_state == ST_BODY) && w_out_free;
    assign w_acc        = i_rx.valid && w_rdy;
    assign w_len_lo     = {r_len[15:8], w_b};
    assign w_data_bytes = r_len - 16'd2;
    assign w_cnt_inc    = r_cnt + CNT_W'(1);
    assign w_cnt16      = 16'(r_cnt);
    assign w_cnt_inc16  = 16'(w_cnt_inc);
    assign w_pos16      = 16'(r_pos);
    assign w_pos_inc    = r_pos + CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_sum    = r_sum;
        n_chk_hi = r_chk_hi;
        n_pos    = r_pos;
        n_hi     = r_hi;
        n_ov     = r_ov && !o_res.ready;
        n_o_idx  = r_o_idx;
        n_o_val  = r_o_val;
        n_o_len  = r_o_len;
        n_o_ok   = r_o_ok;
        n_o_last = r_o_last;
        w_mem_we = 1'b0;
        w_mem_re = 1'b0;
        w_raddr  = r_pos[AW-1:0];

        case (r_state)
            ST_HUNT1: begin
                if (w_acc && w_b == START_FIRST) begin
                    n_sum   = {8'h00, w_b};
                    n_state = ST_HUNT2;
                end
            end
            ST_HUNT2: begin
                if (w_acc) begin
                    if (w_b == START_SECOND) begin
                        n_sum   = r_sum + {8'h00, w_b};
                        n_state = ST_LEN_HI;
                    end else begin
                        n_state = ST_HUNT1;
                    end
                end
            end
            ST_LEN_HI: begin
                if (w_acc) begin
                    n_len   = {w_b, 8'h00};
                    n_sum   = r_sum + {8'h00, w_b};
                    n_state = ST_LEN_LO;
                end
            end
            ST_LEN_LO: begin
                if (w_acc) begin
                    n_len = w_len_lo;
                    n_sum = r_sum + {8'h00, w_b};
                    n_cnt = '0;
                    if (w_len_lo < 16'd2 || w_len_lo > DEPTH16) begin
                        n_ov     = 1'b1;
                        n_o_idx  = '0;
                        n_o_val  = '0;
                        n_o_len  = w_len_lo;
                        n_o_ok   = 1'b0;
                        n_o_last = 1'b1;
                        n_state  = ST_HUNT1;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                if (w_acc) begin
                    w_mem_we = 1'b1;
                    if (w_cnt16 < w_data_bytes) begin
                        n_sum = r_sum + {8'h00, w_b};
                    end
                    if (w_cnt16 == w_data_bytes) begin
                        n_chk_hi = w_b;
                    end
                    n_cnt = w_cnt_inc;
                    if (w_cnt_inc16 == r_len) begin
                        n_cnt = '0;
                        if ({r_chk_hi, w_b} != r_sum) begin
                            n_ov     = 1'b1;
                            n_o_idx  = '0;
                            n_o_val  = '0;
                            n_o_len  = r_len;
                            n_o_ok   = 1'b0;
                            n_o_last = 1'b1;
                            n_state  = ST_HUNT1;
                        end else if (w_data_bytes == 16'd0) begin
                            n_state = ST_HUNT1;
                        end else begin
                            n_pos   = '0;
                            n_state = ST_RDHI;
                        end
                    end
                end
            end
            ST_RDHI: begin
                w_mem_re = 1'b1;
                n_state  = ST_RDLO;
            end
            ST_RDLO: begin
                n_hi     = w_rdata;
                w_mem_re = 1'b1;
                w_raddr  = w_pos_inc[AW-1:0];
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_o_idx  = r_pos[4:1];
                    n_o_val  = {r_hi, (w_pos16 + 16'd1 < w_data_bytes) ? w_rdata : 8'h00};
                    n_o_len  = r_len;
                    n_o_ok   = 1'b1;
                    n_o_last = (w_pos16 + 16'd2 >= w_data_bytes);
                    if (w_pos16 + 16'd2 >= w_data_bytes) begin
                        n_state = ST_HUNT1;
                    end else begin
                        n_pos   = r_pos + CNT_W'(2);
                        n_state = ST_RDHI;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT1;
            r_len   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_pos   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_hi <= n_chk_hi;
        r_hi     <= n_hi;
        r_o_idx  <= n_o_idx;
        r_o_val  <= n_o_val;
        r_o_len  <= n_o_len;
        r_o_ok   <= n_o_ok;
        r_o_last <= n_o_last;
    end

    assign i_rx.ready         = w_rdy;
    assign o_res.valid        = r_ov;
    assign o_res.word_index   = r_o_idx;
    assign o_res.word_value   = r_o_val;
    assign o_res.frame_length = r_o_len;
    assign o_res.frame_ok     = r_o_ok;
    assign o_res.last         = r_o_last;
endmodule

FILE: rtl/sfr_store.sv
// Frame body buffer: one write port, one read port with registered read data.
// Depends on nothing.
module sfr_store #(
    parameter int DEPTH = 28
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/sfr_checker.sv
// Port-level checks for the sensor frame receiver, bound to the top level.
// Depends on sensor_frame_receiver's interface ports.
module sfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rx_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [3:0]  i_res_word_index,
    input logic [15:0] i_res_word_value,
    input logic        i_res_frame_ok,
    input logic        i_res_last
);
    // Stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_word_value))
        else $error("result value changed while stalled");

    // Error results are single, zeroed and terminal.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_frame_ok |->
            i_res_last && i_res_word_value == 16'd0 && i_res_word_index == 4'd0)
        else $error("malformed error result");

    // No byte intake while a frame burst is still running.
    a_burst_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_frame_ok && !i_res_last |-> !i_rx_ready)
        else $error("input ready during word burst");
endmodule

bind sensor_frame_receiver sfr_checker u_sfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rx_ready       (i_rx.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_word_index (o_res.word_index),
    .i_res_word_value (o_res.word_value),
    .i_res_frame_ok   (o_res.frame_ok),
    .i_res_last       (o_res.last)
);

FILE: tb/sensor_frame_receiver_tb.sv
`timescale 1ns / 100ps
// Testbench for sensor_frame_receiver: drives framed sensor byte streams and checks every
// result word against a behavioral frame parser. Depends on sfr_pkg, sfr_if and the RTL top.
module sensor_frame_receiver_tb;
    import sfr_pkg::*;

    localparam int STORE_DEPTH    = MAX_FRAME_BYTES_DEF - 4;
    localparam int RANDOM_BYTES   = 250;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [3:0]  word_index;
        logic [15:0] word_value;
        logic [15:0] frame_length;
        logic        frame_ok;
        logic        last;
    } t_frame_word;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;
    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_LONG_STALL} t_rdy_mode;

    class frame_scoreboard;
        t_state        phase;
        logic [15:0]   frame_len;
        logic [5:0]    body_count;
        logic [15:0]   sum;
        logic [7:0]    body [STORE_DEPTH];
        t_frame_word   pending_words [$];
        int            mismatch_count;

        function new();
            phase          = ST_HUNT1;
            frame_len      = '0;
            body_count     = '0;
            sum            = '0;
            mismatch_count = 0;
        endfunction

        function void push_word(int idx, logic [15:0] value, logic ok, logic last);
            t_frame_word w;
            w.word_index   = 4'(idx);
            w.word_value   = value;
            w.frame_length = frame_len;
            w.frame_ok     = ok;
            w.last         = last;
            pending_words.push_back(w);
        endfunction

        // Frame end: compare the trailing checksum, then unpack data bytes into words
        function void close_frame();
            int len;
            int data_bytes;
            int words;
            logic [15:0] cksum;
            logic [7:0] lo;
            len        = frame_len;
            phase      = ST_HUNT1;
            body_count = '0;
            cksum      = {body[len - 2], body[len - 1]};
            if (cksum != sum) begin
                push_word(0, 16'h0000, 1'b0, 1'b1);
                return;
            end
            data_bytes = len - 2;
            words      = (data_bytes + 1) / 2;
            for (int i = 0; i < words; i++) begin
                lo = (2 * i + 1 < data_bytes) ? body[2 * i + 1] : 8'h00;
                push_word(i, {body[2 * i], lo}, 1'b1, i + 1 == words);
            end
        endfunction

        function void note_rx_byte(logic [7:0] b);
            case (phase)
                ST_HUNT1: begin
                    if (b == START_FIRST) begin
                        sum   = 16'(b);
                        phase = ST_HUNT2;
                    end
                end
                ST_HUNT2: begin
                    // a wrong second byte is dropped, not retried as a first start byte
                    if (b == START_SECOND) begin
                        sum   = sum + 16'(b);
                        phase = ST_LEN_HI;
                    end else begin
                        phase = ST_HUNT1;
                    end
                end
                ST_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    sum       = sum + 16'(b);
                    phase     = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    frame_len[7:0] = b;
                    sum            = sum + 16'(b);
                    body_count     = '0;
                    if (frame_len < 2 || frame_len > STORE_DEPTH) begin
                        push_word(0, 16'h0000, 1'b0, 1'b1);
                        phase = ST_HUNT1;
                    end else begin
                        phase = ST_BODY;
                    end
                end
                ST_BODY: begin
                    body[body_count] = b;
                    if (int'(body_count) < int'(frame_len) - 2) sum = sum + 16'(b);
                    body_count = body_count + 1'b1;
                    if (int'(body_count) >= int'(frame_len)) close_frame();
                end
                default: phase = ST_HUNT1;
            endcase
        endfunction

        function void check_word(t_frame_word got);
            t_frame_word exp;
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result idx=%0d value=%h len=%h ok=%b last=%b",
                             $time, got.word_index, got.word_value, got.frame_length,
                             got.frame_ok, got.last);
                return;
            end
            exp = pending_words.pop_front();
            if (got !== exp) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display({"%0t: result mismatch: expected idx=%0d value=%h len=%h ok=%b ",
                              "last=%b, got idx=%0d value=%h len=%h ok=%b last=%b"},
                             $time, exp.word_index, exp.word_value, exp.frame_length,
                             exp.frame_ok, exp.last, got.word_index, got.word_value,
                             got.frame_length, got.frame_ok, got.last);
            end
        endfunction

        function int pending_count();
            return pending_words.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfr_byte_if rx_if ();
    sfr_word_if res_if ();

    sensor_frame_receiver dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    frame_scoreboard sb = new();
    int  bytes_sent;
    int  burst_left;
    int  idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Input and output monitors
    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready) sb.note_rx_byte(rx_if.rx_byte);
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_word({res_if.word_index, res_if.word_value, res_if.frame_length,
                           res_if.frame_ok, res_if.last});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result-side stall pattern: a random mode is redrawn each time its random run length expires
    initial begin
        t_rdy_mode mode;
        int        mode_left;
        int        phase_cnt;
        mode      = RDY_ALWAYS;
        mode_left = 0;
        phase_cnt = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_rdy_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
                phase_cnt = 0;
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                RDY_ALWAYS:     res_if.ready <= 1'b1;
                RDY_RANDOM:     res_if.ready <= 1'($urandom_range(0, 1));
                RDY_PERIODIC:   res_if.ready <= (phase_cnt % 4 == 0);
                RDY_LONG_STALL: res_if.ready <= (phase_cnt % 20 >= 15);
                default:        res_if.ready <= 1'b1;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0)      gap = $urandom_range(10, 25);
            else if ($urandom_range(0, 2) == 0) gap = 0;
            else                                gap = $urandom_range(1, 4);
            repeat (gap) begin
                rx_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    // Header, then body and checksum when the length is in range
    task automatic send_frame(input logic [15:0] len, input t_fill fill, input bit bad_sum);
        logic [15:0] sum;
        logic [7:0]  d;
        sum = 16'(START_FIRST) + 16'(START_SECOND) + 16'(len[15:8]) + 16'(len[7:0]);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len < 2 || len > STORE_DEPTH) return;
        for (int i = 0; i < int'(len) - 2; i++) begin
            case (fill)
                FILL_ZERO: d = 8'h00;
                FILL_ONES: d = 8'hFF;
                default:   d = 8'($urandom());
            endcase
            sum = sum + 16'(d);
            send_byte(d);
        end
        if (bad_sum) sum = sum ^ (16'h1 << $urandom_range(0, 15));
        send_byte(sum[15:8]);
        send_byte(sum[7:0]);
    endtask

    function automatic logic [15:0] pick_good_len();
        return ($urandom_range(0, 5) == 0) ? 16'(STORE_DEPTH)
                                            : 16'($urandom_range(2, STORE_DEPTH));
    endfunction

    initial begin
        int          kind;
        logic [7:0]  b;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        bytes_sent    = 0;
        burst_left    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty frame, broken start pair, bad lengths, odd count, bad checksum
        send_frame(16'd2, FILL_RANDOM, 1'b0);
        send_byte(START_FIRST);
        send_byte(START_FIRST);
        send_byte(START_SECOND);
        send_frame(16'd1, FILL_RANDOM, 1'b0);
        send_frame(16'hFFFF, FILL_RANDOM, 1'b0);
        send_frame(16'd3, FILL_ZERO, 1'b0);
        send_frame(16'd4, FILL_ONES, 1'b1);
        send_frame(16'(STORE_DEPTH), FILL_ONES, 1'b0);

        // Random: mostly well-formed frames with random content, the rest broken or noise
        while (bytes_sent < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(pick_good_len(), FILL_RANDOM, 1'b0);
            end else if (kind < 80) begin
                send_frame(16'($urandom_range(2, STORE_DEPTH)), FILL_RANDOM, 1'b1);
            end else if (kind < 88) begin
                if ($urandom_range(0, 1) == 0)
                    send_frame(16'($urandom_range(0, 1)), FILL_RANDOM, 1'b0);
                else
                    send_frame(16'($urandom_range(STORE_DEPTH + 1, 65535)), FILL_RANDOM, 1'b0);
            end else if (kind < 94) begin
                send_byte(START_FIRST);
                do b = 8'($urandom()); while (b == START_SECOND);
                send_byte(b);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom()));
            end
        end
        @(negedge i_clk);
        rx_if.valid <= 1'b0;

        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
